FILE: rtl/radix2_fft_zero_padded_core_macros.svh
// Assertion macros for the radix-2 FFT core.
// Used by the top level only; expects clk and rst in scope.
`ifndef RADIX2_FFT_ZERO_PADDED_CORE_MACROS_SVH
`define RADIX2_FFT_ZERO_PADDED_CORE_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define R2FFT_IMPLIES(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define R2FFT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

FILE: rtl/r2fft_pkg.sv
// Shared types, constants and twiddle generation for the radix-2 FFT core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package r2fft_pkg;

  localparam int ACC_BITS    = 27;
  localparam int TW_BITS     = 16;
  localparam int PROD_BITS   = ACC_BITS + TW_BITS;
  localparam int ROUND_SHIFT = 15;
  localparam int TR_BITS     = PROD_BITS + 1 - ROUND_SHIFT;
  localparam int SUM_BITS    = TR_BITS + 1;
  localparam int IDX_BITS    = 10;
  localparam int PL_BITS     = 4;

  localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C234;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic signed [ACC_BITS-1:0] re;
    logic signed [ACC_BITS-1:0] im;
  } cplx_t;

  typedef enum logic [2:0] {
    BF_HOLD,
    BF_LOAD_A,
    BF_LOAD_B,
    BF_M0,
    BF_M1,
    BF_M2,
    BF_M3,
    BF_M4
  } bf_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LEN,
    S_ZERO,
    S_BR_A,
    S_BR_B,
    S_BR_C,
    S_BR_D,
    S_BF_RA,
    S_BF_RB,
    S_BF_LB,
    S_BF_M0,
    S_BF_M1,
    S_BF_M2,
    S_BF_M3,
    S_BF_M4,
    S_BF_WA,
    S_BF_WB,
    S_DONE,
    S_RD_OUT
  } st_t;

  function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [SUM_BITS-1:0] v);
    logic signed [SUM_BITS-1:0] hi;
    logic signed [SUM_BITS-1:0] lo;
    hi = SUM_BITS'((64'sd1 <<< (ACC_BITS - 1)) - 64'sd1);
    lo = SUM_BITS'(-(64'sd1 <<< (ACC_BITS - 1)));
    if (v > hi) return hi[ACC_BITS-1:0];
    if (v < lo) return lo[ACC_BITS-1:0];
    return v[ACC_BITS-1:0];
  endfunction

  function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (Q30_ONE >> 1)) >> 30;
  endfunction

  function automatic logic [15:0] to_q15(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v;
    if (t < 0) t = 0;
    if (t > $signed(Q30_ONE)) t = $signed(Q30_ONE);
    t = (t + 64'sd16384) >>> 15;
    if (t > 64'sd32767) t = 64'sd32767;
    return t[15:0];
  endfunction

  // cos and sin magnitudes of 2*pi*k/2^lg, Q1.15, packed {cos, sin}.
  function automatic logic [31:0] quarter_trig(input int unsigned k, input int unsigned lg);
    logic [63:0] x;
    logic [63:0] ts;
    logic [63:0] tc;
    logic signed [63:0] sum_s;
    logic signed [63:0] sum_c;
    int unsigned i;
    x = ((PI_Q62 >> 12) * 64'(k)) >> (19 + lg);
    ts = x;
    tc = Q30_ONE;
    sum_s = $signed(x);
    sum_c = $signed(Q30_ONE);
    for (i = 1; i <= 15; i++) begin
      ts = q30_mul(q30_mul(ts, x), x) / 64'((2 * i) * (2 * i + 1));
      tc = q30_mul(q30_mul(tc, x), x) / 64'((2 * i - 1) * (2 * i));
      if (i[0]) begin
        sum_s = sum_s - $signed(ts);
        sum_c = sum_c - $signed(tc);
      end else begin
        sum_s = sum_s + $signed(ts);
        sum_c = sum_c + $signed(tc);
      end
    end
    return {to_q15(sum_c), to_q15(sum_s)};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/r2fft_if.sv
// Request and response channel interfaces for the radix-2 FFT core.
// Depends on r2fft_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface r2fft_in_if import r2fft_pkg::*; #(parameter int SAMPLE_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [1:0]             command;
  logic [SAMPLE_BITS-1:0] sample;
  logic [IDX_BITS-1:0]    bin_index;

  modport source (output valid, command, sample, bin_index, input ready);
  modport sink (input valid, command, sample, bin_index, output ready);
endinterface

interface r2fft_out_if import r2fft_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [ACC_BITS-1:0] bin_real;
  logic signed [ACC_BITS-1:0] bin_imag;
  logic                       bin_valid;
  logic [PL_BITS-1:0]         points_log2;

  modport source (output valid, bin_real, bin_imag, bin_valid, points_log2, input ready);
  modport sink (input valid, bin_real, bin_imag, bin_valid, points_log2, output ready);
endinterface

`default_nettype wire

FILE: rtl/radix2_fft_zero_padded_core.sv
// Top level of the zero-padded radix-2 FFT core: command decode, run sequencer.
// Depends on r2fft_pkg, r2fft_if, r2fft_ram, r2fft_twiddle, r2fft_bfly.
//
// Usage: requests arrive on req (command, sample, bin_index), results leave on rsp.
// A load request stores one sample; loads past capacity are dropped, and
// the first load after a finished run starts a new frame.
// A run request pads the frame with zeros to N = 2^lg and transforms it in place.
// A run searches for the length, fills the frame with zeros from count up to N,
// swaps each bit-reversed pair, then computes N/2*lg butterflies, each of which
// reads two words, uses the single multiplier four times (not at all for twiddle
// index zero) and writes two words through the one RAM write port, and finishes.
// req.ready is low for the whole run.
// A read request loads the RAM data into the response register once it is free, raising rsp.valid.
// If rsp is stalled the response holds in its register; loads and runs still go
// ahead, and a further read waits with req not ready until the register frees.
// Reset clears the frame count, length and done flag; the work RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

`include "radix2_fft_zero_padded_core_macros.svh"

module radix2_fft_zero_padded_core import r2fft_pkg::*; #(
  parameter int MAX_POINTS  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input logic         clk,
  input logic         rst,
  r2fft_in_if.sink    req,
  r2fft_out_if.source rsp
);

  localparam int AW = $clog2(MAX_POINTS + 1) - 1;
  localparam int P  = 1 << AW;
  localparam int CW = AW + 1;
  localparam int LW = $clog2(AW + 1);
  localparam int IW = (AW > IDX_BITS) ? AW : IDX_BITS;

  st_t            state;
  st_t            state_next;
  logic [CW-1:0]  count;
  logic [CW-1:0]  n;
  logic [CW-1:0]  cnt;
  logic [LW-1:0]  lg;
  logic [LW-1:0]  s;
  logic           done;
  logic           rd_ok;
  cplx_t          di;

  logic                       out_valid;
  logic signed [ACC_BITS-1:0] out_real;
  logic signed [ACC_BITS-1:0] out_imag;
  logic                       out_bin_valid;
  logic [PL_BITS-1:0]         out_pl;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  cplx_t         ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  cplx_t         ram_rdata;

  logic          req_fire;
  cmd_t          cmd;
  cplx_t         sample_word;
  logic [IW-1:0] idx_ext;
  logic          in_range;
  logic [AW-1:0] i_addr;
  logic [AW-1:0] rev;
  logic [AW-1:0] r_addr;
  logic          swap;
  logic          br_last;
  logic [AW-1:0] j;
  logic [AW-1:0] hmask;
  logic [AW-1:0] a_addr;
  logic [AW-1:0] b_addr;
  logic [AW-1:0] tw_u;
  logic [CW-1:0] half_m1;
  logic          bf_last;
  logic          rsp_free;

  bf_op_t                    bf_op;
  logic signed [TW_BITS-1:0] tw_re;
  logic signed [TW_BITS-1:0] tw_im;
  logic                      tw_bypass;
  cplx_t                     bf_sum;
  cplx_t                     bf_diff;

  r2fft_ram #(
    .WIDTH ($bits(cplx_t)),
    .DEPTH (P)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  r2fft_twiddle #(
    .ADDR_BITS (AW)
  ) u_twiddle (
    .u      (tw_u),
    .tw_re  (tw_re),
    .tw_im  (tw_im),
    .bypass (tw_bypass)
  );

  r2fft_bfly u_bfly (
    .clk   (clk),
    .op    (bf_op),
    .rd    (ram_rdata),
    .tw_re (tw_re),
    .tw_im (tw_im),
    .sum   (bf_sum),
    .diff  (bf_diff)
  );

  always_comb begin
    req_fire       = req.valid && req.ready;
    cmd            = cmd_t'(req.command);
    sample_word.re = ACC_BITS'($signed(req.sample[SAMPLE_BITS-1:0]));
    sample_word.im = '0;
    idx_ext        = IW'(req.bin_index);
    in_range       = (idx_ext >> lg) == '0;
    rsp_free       = !out_valid || rsp.ready;

    i_addr = cnt[AW-1:0];
    for (int b = 0; b < AW; b++) begin
      rev[b] = i_addr[AW-1-b];
    end
    r_addr  = rev >> (CW'(AW) - CW'(lg));
    swap    = r_addr > i_addr;
    br_last = cnt == (n - CW'(1));

    j       = cnt[AW-1:0];
    hmask   = (AW'(1) << s) - AW'(1);
    a_addr  = ((j >> s) << (s + LW'(1))) | (j & hmask);
    b_addr  = a_addr | (AW'(1) << s);
    tw_u    = (j & hmask) << (LW'(AW - 1) - s);
    half_m1 = (n >> 1) - CW'(1);
    bf_last = cnt == half_m1;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          case (cmd)
            CMD_RUN: begin
              if (!done && count != '0) state_next = S_LEN;
            end
            CMD_READ: state_next = S_RD_OUT;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_LEN: begin
        if (n >= count) state_next = S_ZERO;
      end
      S_ZERO: begin
        if (cnt >= n) state_next = S_BR_A;
      end
      S_BR_A: begin
        if (swap) state_next = S_BR_B;
        else if (br_last) state_next = (lg == '0) ? S_DONE : S_BF_RA;
      end
      S_BR_B: state_next = S_BR_C;
      S_BR_C: state_next = S_BR_D;
      S_BR_D: begin
        if (br_last) state_next = (lg == '0) ? S_DONE : S_BF_RA;
        else state_next = S_BR_A;
      end
      S_BF_RA: state_next = S_BF_RB;
      S_BF_RB: state_next = S_BF_LB;
      S_BF_LB: state_next = tw_bypass ? S_BF_WA : S_BF_M0;
      S_BF_M0: state_next = S_BF_M1;
      S_BF_M1: state_next = S_BF_M2;
      S_BF_M2: state_next = S_BF_M3;
      S_BF_M3: state_next = S_BF_M4;
      S_BF_M4: state_next = S_BF_WA;
      S_BF_WA: state_next = S_BF_WB;
      S_BF_WB: begin
        if (bf_last && s == lg - LW'(1)) state_next = S_DONE;
        else state_next = S_BF_RA;
      end
      S_DONE: state_next = S_IDLE;
      S_RD_OUT: begin
        if (rsp_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    bf_op     = BF_HOLD;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        ram_we    = req_fire && cmd == CMD_LOAD && (done || count < CW'(P));
        ram_waddr = done ? '0 : count[AW-1:0];
        ram_wdata = sample_word;
        ram_re    = req_fire && cmd == CMD_READ;
        ram_raddr = idx_ext[AW-1:0];
      end
      S_ZERO: begin
        ram_we    = cnt < n;
        ram_waddr = cnt[AW-1:0];
      end
      S_BR_A: begin
        ram_re    = 1'b1;
        ram_raddr = i_addr;
      end
      S_BR_B: begin
        ram_re    = 1'b1;
        ram_raddr = r_addr;
      end
      S_BR_C: begin
        ram_we    = 1'b1;
        ram_waddr = i_addr;
        ram_wdata = ram_rdata;
      end
      S_BR_D: begin
        ram_we    = 1'b1;
        ram_waddr = r_addr;
        ram_wdata = di;
      end
      S_BF_RA: begin
        ram_re    = 1'b1;
        ram_raddr = a_addr;
      end
      S_BF_RB: begin
        ram_re    = 1'b1;
        ram_raddr = b_addr;
        bf_op     = BF_LOAD_A;
      end
      S_BF_LB: bf_op = BF_LOAD_B;
      S_BF_M0: bf_op = BF_M0;
      S_BF_M1: bf_op = BF_M1;
      S_BF_M2: bf_op = BF_M2;
      S_BF_M3: bf_op = BF_M3;
      S_BF_M4: bf_op = BF_M4;
      S_BF_WA: begin
        ram_we    = 1'b1;
        ram_waddr = a_addr;
        ram_wdata = bf_sum;
      end
      S_BF_WB: begin
        ram_we    = 1'b1;
        ram_waddr = b_addr;
        ram_wdata = bf_diff;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      n         <= '0;
      cnt       <= '0;
      lg        <= '0;
      s         <= '0;
      done      <= 1'b0;
      rd_ok     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && rsp.ready && state != S_RD_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            case (cmd)
              CMD_LOAD: begin
                if (done) begin
                  done  <= 1'b0;
                  count <= CW'(1);
                end else if (count < CW'(P)) begin
                  count <= count + CW'(1);
                end
              end
              CMD_RUN: begin
                if (!done) begin
                  lg <= '0;
                  n  <= CW'(1);
                end
              end
              CMD_READ: rd_ok <= done && in_range;
              default: begin
              end
            endcase
          end
        end
        S_LEN: begin
          if (n < count) begin
            n  <= n << 1;
            lg <= lg + LW'(1);
          end else begin
            cnt <= count;
          end
        end
        S_ZERO: begin
          if (cnt < n) cnt <= cnt + CW'(1);
          else cnt <= '0;
        end
        S_BR_A: begin
          if (!swap) begin
            if (br_last) begin
              cnt <= '0;
              s   <= '0;
            end else begin
              cnt <= cnt + CW'(1);
            end
          end
        end
        S_BR_B: di <= ram_rdata;
        S_BR_D: begin
          if (br_last) begin
            cnt <= '0;
            s   <= '0;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_BF_WB: begin
          if (bf_last) begin
            cnt <= '0;
            s   <= s + LW'(1);
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_DONE: done <= 1'b1;
        S_RD_OUT: begin
          if (rsp_free) begin
            out_valid     <= 1'b1;
            out_real      <= rd_ok ? ram_rdata.re : '0;
            out_imag      <= rd_ok ? ram_rdata.im : '0;
            out_bin_valid <= rd_ok;
            out_pl        <= PL_BITS'(lg);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.bin_real    = out_real;
  assign rsp.bin_imag    = out_imag;
  assign rsp.bin_valid   = out_bin_valid;
  assign rsp.points_log2 = out_pl;

  `R2FFT_IMPLIES(a_count_cap, 1'b1, count <= CW'(P), "sample count beyond frame capacity")
  `R2FFT_IMPLIES(a_invalid_zero, out_valid && !out_bin_valid, out_real == '0 && out_imag == '0, "invalid bin carries nonzero parts")
  `R2FFT_IMPLIES(a_bf_index, state == S_BF_WB, cnt <= half_m1, "butterfly index past stage end")
  `R2FFT_NEXT(a_run_done, state == S_DONE, done, "run finished without done flag")

endmodule

`default_nettype wire

FILE: rtl/r2fft_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module r2fft_ram #(
  parameter int WIDTH = 54,
  parameter int DEPTH = 1024,
  localparam int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [ABITS-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/r2fft_twiddle.sv
// Quarter-wave twiddle table and lookup for the full transform length.
// Depends on r2fft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module r2fft_twiddle import r2fft_pkg::*; #(
  parameter int ADDR_BITS = 10
) (
  input  logic [ADDR_BITS-1:0]       u,
  output logic signed [TW_BITS-1:0]  tw_re,
  output logic signed [TW_BITS-1:0]  tw_im,
  output logic                       bypass
);

  localparam int QN   = (1 << ADDR_BITS) / 4;
  localparam int HALF = (1 << ADDR_BITS) / 2;
  localparam int TI   = (ADDR_BITS > 1) ? ADDR_BITS - 1 : 1;

  logic [31:0]          rom [QN+1];
  logic                 upper;
  logic [ADDR_BITS-1:0] mir;
  logic [TI-1:0]        tidx;
  logic [31:0]          ent;

  for (genvar g = 0; g <= QN; g++) begin : g_rom
    localparam logic [31:0] E = quarter_trig(g, ADDR_BITS);
    assign rom[g] = E;
  end

  always_comb begin
    upper  = u > ADDR_BITS'(QN);
    mir    = ADDR_BITS'(HALF) - u;
    tidx   = upper ? mir[TI-1:0] : u[TI-1:0];
    ent    = rom[tidx];
    tw_re  = upper ? -$signed(ent[31:16]) : $signed(ent[31:16]);
    tw_im  = -$signed(ent[15:0]);
    bypass = (u == '0);
  end

endmodule

`default_nettype wire

FILE: rtl/r2fft_bfly.sv
// Butterfly datapath: one shared multiplier over four passes, rounding,
// saturating sum and difference. Depends on r2fft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module r2fft_bfly import r2fft_pkg::*; (
  input  logic                      clk,
  input  bf_op_t                    op,
  input  cplx_t                     rd,
  input  logic signed [TW_BITS-1:0] tw_re,
  input  logic signed [TW_BITS-1:0] tw_im,
  output cplx_t                     sum,
  output cplx_t                     diff
);

  cplx_t                       a;
  cplx_t                       b;
  logic signed [TW_BITS-1:0]   twr;
  logic signed [TW_BITS-1:0]   twi;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [PROD_BITS-1:0] acc;
  logic signed [TR_BITS-1:0]   tr;
  logic signed [TR_BITS-1:0]   ti;

  logic signed [ACC_BITS-1:0]  ma;
  logic signed [TW_BITS-1:0]   mb;
  logic signed [PROD_BITS:0]   pre_re;
  logic signed [PROD_BITS:0]   pre_im;

  always_comb begin
    ma = ((op == BF_M0) || (op == BF_M2)) ? b.re : b.im;
    mb = ((op == BF_M0) || (op == BF_M3)) ? twr : twi;
    pre_re = (PROD_BITS+1)'(acc) - (PROD_BITS+1)'(prod) + (PROD_BITS+1)'(16384);
    pre_im = (PROD_BITS+1)'(acc) + (PROD_BITS+1)'(prod) + (PROD_BITS+1)'(16384);
    sum.re  = sat_acc(SUM_BITS'(a.re) + SUM_BITS'(tr));
    sum.im  = sat_acc(SUM_BITS'(a.im) + SUM_BITS'(ti));
    diff.re = sat_acc(SUM_BITS'(a.re) - SUM_BITS'(tr));
    diff.im = sat_acc(SUM_BITS'(a.im) - SUM_BITS'(ti));
  end

  always_ff @(posedge clk) begin
    case (op)
      BF_LOAD_A: begin
        a <= rd;
      end
      BF_LOAD_B: begin
        b   <= rd;
        tr  <= TR_BITS'(rd.re);
        ti  <= TR_BITS'(rd.im);
        twr <= tw_re;
        twi <= tw_im;
      end
      BF_M0: begin
        prod <= ma * mb;
      end
      BF_M1: begin
        acc  <= prod;
        prod <= ma * mb;
      end
      BF_M2: begin
        tr   <= pre_re[PROD_BITS:ROUND_SHIFT];
        prod <= ma * mb;
      end
      BF_M3: begin
        acc  <= prod;
        prod <= ma * mb;
      end
      BF_M4: begin
        ti <= pre_im[PROD_BITS:ROUND_SHIFT];
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking bench for radix2_fft_zero_padded_core: loads, runs and bin reads
// over valid/ready channels, checked against an in-bench fixed-point FFT predictor.
// Depends on r2fft_pkg, r2fft_if and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import r2fft_pkg::*;

  localparam int FRAME_CAP = 1024;
  localparam logic [63:0] PI_Q62_TB = 64'hC90FDAA22168C234;
  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam longint ACC_HI = (64'sd1 <<< (ACC_BITS - 1)) - 1;
  localparam longint ACC_LO = -(64'sd1 <<< (ACC_BITS - 1));

  typedef struct {
    logic signed [ACC_BITS-1:0] re;
    logic signed [ACC_BITS-1:0] im;
    logic                       ok;
    logic [PL_BITS-1:0]         pl;
  } bin_t;

  typedef struct {
    cmd_t                c;
    logic [15:0]         s;
    logic [IDX_BITS-1:0] b;
    bit                  typed;
    bin_t                exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  r2fft_in_if #(.SAMPLE_BITS(16)) req_if ();
  r2fft_out_if rsp_if ();

  radix2_fft_zero_padded_core dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state
  longint spec_re[FRAME_CAP];
  longint spec_im[FRAME_CAP];
  longint tw_c[FRAME_CAP/2];
  longint tw_s[FRAME_CAP/2];
  int unsigned frame_fill = 0;
  int unsigned fft_lg = 0;
  bit fft_done = 1'b0;

  bin_t pending_bins[$];
  row_t rows[$];
  int errors = 0;
  int n_items = 0;
  int n_bins = 0;
  int n_runs = 0;
  int max_lg = 0;
  bit quiet_tx = 1'b0;
  bit quiet_rx = 1'b0;
  bit hold_rsp = 1'b0;
  bit stim_done = 1'b0;

  function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
    return (a * b + 64'd536870912) >> 30;
  endfunction

  function automatic longint clamp_q15(longint v);
    if (v < 0) v = 0;
    if (v > ONE_Q30) v = ONE_Q30;
    v = (v + 16384) >>> 15;
    return (v > 32767) ? 32767 : v;
  endfunction

  task automatic trig_q15(input int unsigned k, input int unsigned lg,
                          output longint c, output longint s);
    logic [63:0] x;
    logic [63:0] ps;
    logic [63:0] pc;
    longint acc_s;
    longint acc_c;
    x = ((PI_Q62_TB >> 12) * 64'(k)) >> (19 + lg);
    ps = x;
    pc = 64'(ONE_Q30);
    acc_s = longint'(x);
    acc_c = ONE_Q30;
    for (int i = 1; i <= 15; i++) begin
      ps = mul_q30(mul_q30(ps, x), x) / 64'((2 * i) * (2 * i + 1));
      pc = mul_q30(mul_q30(pc, x), x) / 64'((2 * i - 1) * (2 * i));
      if (i % 2 == 1) begin
        acc_s -= longint'(ps);
        acc_c -= longint'(pc);
      end else begin
        acc_s += longint'(ps);
        acc_c += longint'(pc);
      end
    end
    c = clamp_q15(acc_c);
    s = clamp_q15(acc_s);
  endtask

  function automatic longint sat27(longint v);
    return (v > ACC_HI) ? ACC_HI : ((v < ACC_LO) ? ACC_LO : v);
  endfunction

  task automatic transform_frame();
    int unsigned n;
    int unsigned lg;
    int unsigned r;
    int unsigned stride;
    int unsigned a;
    int unsigned b;
    int unsigned w;
    longint c;
    longint s;
    longint tr;
    longint ti;
    longint ar;
    longint ai;
    longint t;
    n = 1;
    lg = 0;
    while (n < frame_fill) begin
      n <<= 1;
      lg++;
    end
    for (int unsigned i = frame_fill; i < n; i++) begin
      spec_re[i] = 0;
      spec_im[i] = 0;
    end
    for (int unsigned i = 1; i < n / 2; i++) begin
      if (i <= n / 4) begin
        trig_q15(i, lg, c, s);
        tw_c[i] = c;
      end else begin
        trig_q15(n / 2 - i, lg, c, s);
        tw_c[i] = -c;
      end
      tw_s[i] = -s;
    end
    for (int unsigned i = 0; i < n; i++) begin
      r = 0;
      for (int unsigned k = 0; k < lg; k++) r |= ((i >> k) & 1) << (lg - 1 - k);
      if (r > i) begin
        t = spec_re[i]; spec_re[i] = spec_re[r]; spec_re[r] = t;
        t = spec_im[i]; spec_im[i] = spec_im[r]; spec_im[r] = t;
      end
    end
    for (int unsigned half = 1; half < n; half <<= 1) begin
      stride = n / (2 * half);
      for (int unsigned base = 0; base < n; base += 2 * half) begin
        for (int unsigned k = 0; k < half; k++) begin
          a = base + k;
          b = a + half;
          w = k * stride;
          ar = spec_re[a];
          ai = spec_im[a];
          if (w == 0) begin
            tr = spec_re[b];
            ti = spec_im[b];
          end else begin
            tr = (spec_re[b] * tw_c[w] - spec_im[b] * tw_s[w] + 16384) >>> 15;
            ti = (spec_re[b] * tw_s[w] + spec_im[b] * tw_c[w] + 16384) >>> 15;
          end
          spec_re[a] = sat27(ar + tr);
          spec_im[a] = sat27(ai + ti);
          spec_re[b] = sat27(ar - tr);
          spec_im[b] = sat27(ai - ti);
        end
      end
    end
    fft_lg = lg;
    fft_done = 1'b1;
    if (lg > max_lg) max_lg = lg;
    n_runs++;
  endtask

  // apply one accepted request to the predictor; returns 1 when a bin comes back
  task automatic predict_bin(input cmd_t c, input logic [15:0] s,
                             input logic [IDX_BITS-1:0] b, output bit has, output bin_t e);
    has = 1'b0;
    e = '{default: '0};
    case (c)
      CMD_LOAD: begin
        if (fft_done) begin
          fft_done = 1'b0;
          frame_fill = 0;
        end
        if (frame_fill < FRAME_CAP) begin
          spec_re[frame_fill] = longint'($signed(s));
          spec_im[frame_fill] = 0;
          frame_fill++;
        end
      end
      CMD_RUN: begin
        if (!fft_done) begin
          if (frame_fill == 0) fft_lg = 0;
          else transform_frame();
        end
      end
      CMD_READ: begin
        has = 1'b1;
        e.ok = fft_done && (b < (1 << fft_lg));
        e.re = e.ok ? spec_re[b][ACC_BITS-1:0] : '0;
        e.im = e.ok ? spec_im[b][ACC_BITS-1:0] : '0;
        e.pl = fft_lg[PL_BITS-1:0];
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 8);
  endfunction

  // send one request; called and returns aligned to a rising edge
  task automatic send_req(input cmd_t c, input logic [15:0] s, input logic [IDX_BITS-1:0] b,
                          input bit typed, input bin_t typed_exp);
    int gap;
    bit has;
    bin_t e;
    gap = draw_gap(quiet_tx);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.command <= c;
    req_if.sample <= s;
    req_if.bin_index <= b;
    do @(posedge clk); while (!req_if.ready);
    predict_bin(c, s, b, has, e);
    if (has) begin
      pending_bins.push_back(typed ? typed_exp : e);
      n_bins++;
    end
    n_items++;
    if (n_items % 64 == 0) quiet_tx = ($urandom_range(0, 3) == 0);
  endtask

  function automatic void add_row(cmd_t c, logic [15:0] s, logic [IDX_BITS-1:0] b,
                                  bit typed = 0, longint re = 0, longint im = 0,
                                  bit ok = 0, int pl = 0);
    row_t r;
    r.c = c;
    r.s = s;
    r.b = b;
    r.typed = typed;
    r.exp.re = re[ACC_BITS-1:0];
    r.exp.im = im[ACC_BITS-1:0];
    r.exp.ok = ok;
    r.exp.pl = pl[PL_BITS-1:0];
    rows.push_back(r);
  endfunction

  task automatic send_rand(input cmd_t c, input int unsigned lim);
    logic [15:0] s;
    case ($urandom_range(0, 9))
      0: s = 16'h7fff;
      1: s = 16'h8000;
      default: s = $urandom;
    endcase
    send_req(c, s, $urandom_range(0, lim), 1'b0, '{default: '0});
  endtask

  // response side
  initial begin
    int stall;
    bin_t e;
    rsp_if.ready = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      stall = draw_gap(quiet_rx);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      if (pending_bins.size() == 0) begin
        report("response with no request outstanding");
      end else begin
        e = pending_bins.pop_front();
        if (rsp_if.bin_real !== e.re)
          report($sformatf("bin_real %0d, want %0d", rsp_if.bin_real, e.re));
        if (rsp_if.bin_imag !== e.im)
          report($sformatf("bin_imag %0d, want %0d", rsp_if.bin_imag, e.im));
        if (rsp_if.bin_valid !== e.ok)
          report($sformatf("bin_valid %0b, want %0b", rsp_if.bin_valid, e.ok));
        if (rsp_if.points_log2 !== e.pl)
          report($sformatf("points_log2 %0d, want %0d", rsp_if.points_log2, e.pl));
      end
      if ($urandom_range(0, 40) == 0) quiet_rx = !quiet_rx;
    end
  end

  initial begin
    #30ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    int fsize;
    int nreads;
    int frames;
    int waited;
    req_if.valid = 1'b0;
    req_if.command = CMD_NONE;
    req_if.sample = '0;
    req_if.bin_index = '0;

    add_row(CMD_READ, 0, 0, 1, 0, 0, 0, 0);
    add_row(CMD_RUN, 0, 0);
    add_row(CMD_READ, 0, 3, 1, 0, 0, 0, 0);
    add_row(CMD_NONE, 16'h1234, 5);
    add_row(CMD_LOAD, 5, 0);
    add_row(CMD_RUN, 0, 0);
    add_row(CMD_READ, 0, 0, 1, 5, 0, 1, 0);
    add_row(CMD_READ, 0, 1, 1, 0, 0, 0, 0);
    add_row(CMD_RUN, 0, 0);
    add_row(CMD_READ, 0, 0, 1, 5, 0, 1, 0);
    add_row(CMD_LOAD, 16'h7fff, 0);
    add_row(CMD_LOAD, 16'h8000, 0);
    add_row(CMD_READ, 0, 0, 1, 0, 0, 0, 0);
    add_row(CMD_RUN, 0, 0);
    add_row(CMD_READ, 0, 0, 1, -1, 0, 1, 1);
    add_row(CMD_READ, 0, 1, 1, 65535, 0, 1, 1);
    add_row(CMD_READ, 0, 1023, 1, 0, 0, 0, 1);
    add_row(CMD_LOAD, 1, 0);
    add_row(CMD_LOAD, 2, 0);
    add_row(CMD_LOAD, 16'hfffd, 0);
    add_row(CMD_RUN, 0, 0);
    add_row(CMD_READ, 0, 1);
    add_row(CMD_READ, 0, 2);
    add_row(CMD_READ, 0, 3);
    add_row(CMD_READ, 0, 4, 1, 0, 0, 0, 2);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i]) send_req(rows[i].c, rows[i].s, rows[i].b, rows[i].typed, rows[i].exp);

    frames = 0;
    while (n_items < 1600) begin
      frames++;
      if (frames == 3) fsize = 1030;
      else if (frames == 4) fsize = 513;
      else if ($urandom_range(0, 3) == 0) fsize = $urandom_range(33, 128);
      else fsize = $urandom_range(1, 32);
      if ($urandom_range(0, 5) == 0) send_rand(CMD_NONE, 1023);
      for (int i = 0; i < fsize; i++) send_rand(CMD_LOAD, 0);
      if ($urandom_range(0, 4) == 0) send_rand(CMD_READ, 1023);
      send_rand(CMD_RUN, 0);
      if ($urandom_range(0, 4) == 0) send_rand(CMD_RUN, 0);
      if (frames == 2) hold_rsp = 1'b1;
      nreads = (frames == 2) ? 24 : $urandom_range(4, 12);
      for (int i = 0; i < nreads; i++) begin
        if ($urandom_range(0, 4) == 0) send_rand(CMD_READ, 1023);
        else send_rand(CMD_READ, (1 << fft_lg) - 1);
      end
    end
    req_if.valid <= 1'b0;

    waited = 0;
    while (pending_bins.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (pending_bins.size() != 0) report($sformatf("%0d bins never returned", pending_bins.size()));

    $display("Covered %0d requests over %0d frames: %0d transforms up to 2^%0d points,",
             n_items, frames, n_runs, max_lg);
    $display("%0d bin reads checked, %0d mismatches.", n_bins, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
